// ----- rtl/rtc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rtc_pkg;

	localparam logic [1:0] KIND_ENC = 2'd0;
	localparam logic [1:0] KIND_DEC = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_COUNT   = 2'd1;
	localparam logic [1:0] ERR_TRAILER = 2'd2;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	typedef struct packed {
		logic [1:0]  kind;
		logic [23:0] data;
		logic        tail;
		logic [1:0]  cnt;
		logic [1:0]  err;
	} job_t;

	function automatic logic [7:0] sym_of(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v == 6'd0) return CH_DOT;
		if (v == 6'd1) return CH_COMMA;
		if (v < 6'd12) return w + (CH_ZERO - 8'd2);
		if (v < 6'd38) return w + (CH_UA - 8'd12);
		return w + (CH_LA - 8'd38);
	endfunction

	function automatic logic [5:0] val_of(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c == CH_COMMA) d = 8'd1;
		else if (c >= CH_ZERO && c <= CH_NINE) d = c - CH_ZERO + 8'd2;
		else if (c >= CH_UA && c <= CH_UZ) d = c - CH_UA + 8'd12;
		else if (c >= CH_LA && c <= CH_LZ) d = c - CH_LA + 8'd38;
		return d[5:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rtc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface rtc_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;
	modport source (output valid, in_byte, in_last, input ready);
	modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface rtc_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_last;
	logic [1:0] out_error;
	modport source (output valid, out_byte, out_valid, out_last, out_error, input ready);
	modport sink (input valid, out_byte, out_valid, out_last, out_error, output ready);
endinterface

interface rtc_cfg_if;
	logic valid;
	logic ready;
	logic direction;
	modport source (output valid, direction, input ready);
	modport sink (input valid, direction, output ready);
endinterface
`default_nettype wire

// ----- rtl/radix64_text_codec.sv -----
`timescale 1ns / 1ps
`default_nettype none
// The first word of a result appears once its job has passed the job queue into the emit unit.
// Throughput: one result word per cycle from the emit unit while result.ready is high;
// encoding gives 4 words per 3 input words plus a trailer, so 5 words for a one-byte
// object; decoding takes one character per cycle while the job queue has room.
// Input words enter every cycle while the QUEUE_DEPTH-entry job queue has room.
// Reset (arst_n low, asynchronous) selects encode, clears group state, queue and emit unit.
module radix64_text_codec import rtc_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	rtc_cfg_if.sink      cfg,
	rtc_item_if.sink     item,
	rtc_result_if.source result
);

	logic push, pop, full, empty;
	job_t wr_job, head;

	rtc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.full   (full),
		.push   (push),
		.job    (wr_job)
	);

	rtc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	rtc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule
`default_nettype wire

// ----- rtl/rtc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rtc_front import rtc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	rtc_item_if.sink     item,
	rtc_cfg_if.sink      cfg,
	input  logic         full,
	output logic         push,
	output job_t         job
);

	logic        dir_q;
	logic [1:0]  gp_q, gp_d;
	logic [17:0] pb_q, pb_d;
	logic [23:0] held_q, held_d;
	logic        pend_q, pend_d;
	logic        job_ok;
	logic        accept;
	logic        cfg_wr;
	logic [15:0] pb_enc;
	logic [1:0]  gp_inc;
	logic [5:0]  sym;

	assign cfg.ready  = 1'b1;
	assign item.ready = !full;
	assign accept     = item.valid && item.ready;
	assign cfg_wr     = cfg.valid && cfg.ready;
	assign push       = accept && job_ok;

	always_comb begin
		gp_d     = gp_q;
		pb_d     = pb_q;
		held_d   = held_q;
		pend_d   = pend_q;
		job_ok   = 1'b0;
		job.kind = KIND_ENC;
		job.data = 24'h0;
		job.tail = 1'b0;
		job.cnt  = 2'd0;
		job.err  = ERR_NONE;
		pb_enc   = {pb_q[7:0], item.in_byte};
		gp_inc   = gp_q + 2'd1;
		sym      = val_of(item.in_byte);
		if (!dir_q) begin
			if (gp_q >= 2'd2) begin
				job_ok   = 1'b1;
				job.data = {pb_q[15:0], item.in_byte};
				job.tail = item.in_last;
				job.cnt  = 2'd3;
				gp_d     = 2'd0;
				pb_d     = 18'h0;
				if (item.in_last) begin
					held_d = 24'h0;
					pend_d = 1'b0;
				end
			end else begin
				gp_d = gp_inc;
				pb_d = {2'b00, pb_enc};
				if (item.in_last) begin
					job_ok   = 1'b1;
					job.tail = 1'b1;
					job.cnt  = gp_inc;
					job.data = (gp_inc == 2'd1) ? {pb_enc[7:0], 16'h0} : {pb_enc, 8'h0};
					gp_d     = 2'd0;
					pb_d     = 18'h0;
					held_d   = 24'h0;
					pend_d   = 1'b0;
				end
			end
		end else if (item.in_last) begin
			job_ok = 1'b1;
			if (gp_q != 2'd0 || !pend_q) begin
				job.kind = KIND_ERR;
				job.err  = ERR_COUNT;
			end else if (item.in_byte < CH_ONE || item.in_byte > CH_THREE) begin
				job.kind = KIND_ERR;
				job.err  = ERR_TRAILER;
			end else begin
				job.kind = KIND_DEC;
				job.data = held_q;
				job.tail = 1'b1;
				job.cnt  = item.in_byte[1:0];
			end
			gp_d   = 2'd0;
			pb_d   = 18'h0;
			held_d = 24'h0;
			pend_d = 1'b0;
		end else if (gp_q == 2'd3) begin
			job_ok   = pend_q;
			job.kind = KIND_DEC;
			job.data = held_q;
			job.cnt  = 2'd3;
			held_d   = {pb_q, sym};
			pend_d   = 1'b1;
			gp_d     = 2'd0;
			pb_d     = 18'h0;
		end else begin
			pb_d = {pb_q[11:0], sym};
			gp_d = gp_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= 1'b0;
			gp_q   <= 2'd0;
			pb_q   <= 18'h0;
			held_q <= 24'h0;
			pend_q <= 1'b0;
		end else if (cfg_wr) begin
			dir_q  <= cfg.direction;
			gp_q   <= 2'd0;
			pb_q   <= 18'h0;
			held_q <= 24'h0;
			pend_q <= 1'b0;
		end else if (accept) begin
			gp_q   <= gp_d;
			pb_q   <= pb_d;
			held_q <= held_d;
			pend_q <= pend_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/rtc_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rtc_fifo import rtc_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	input  logic pop,
	output job_t head,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = cnt_q == FULL_CNT;
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/rtc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rtc_back import rtc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  job_t          head,
	output logic          pop,
	rtc_result_if.source  result
);

	job_t       cur_q;
	logic       busy_q;
	logic [2:0] idx_q;
	logic [2:0] fin;
	logic       is_final;
	logic       fire;
	logic [5:0] six;

	always_comb begin
		case (cur_q.kind)
			KIND_ENC: fin = cur_q.tail ? 3'd4 : 3'd3;
			KIND_DEC: fin = {1'b0, cur_q.cnt - 2'd1};
			default:  fin = 3'd0;
		endcase
	end

	assign is_final     = idx_q == fin;
	assign result.valid = busy_q;
	assign fire         = result.valid && result.ready;
	assign pop          = !empty && (!busy_q || (fire && is_final));

	always_comb begin
		case (idx_q[1:0])
			2'd0:    six = cur_q.data[23:18];
			2'd1:    six = cur_q.data[17:12];
			2'd2:    six = cur_q.data[11:6];
			default: six = cur_q.data[5:0];
		endcase
		result.out_byte  = 8'h0;
		result.out_valid = 1'b1;
		result.out_last  = 1'b0;
		result.out_error = ERR_NONE;
		case (cur_q.kind)
			KIND_ENC: begin
				result.out_byte = idx_q[2] ? CH_ZERO + {6'b0, cur_q.cnt} : sym_of(six);
				result.out_last = idx_q[2];
			end
			KIND_DEC: begin
				case (idx_q[1:0])
					2'd0:    result.out_byte = cur_q.data[23:16];
					2'd1:    result.out_byte = cur_q.data[15:8];
					default: result.out_byte = cur_q.data[7:0];
				endcase
				result.out_last = cur_q.tail && is_final;
			end
			default: begin
				result.out_valid = 1'b0;
				result.out_last  = 1'b1;
				result.out_error = cur_q.err;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= 3'd0;
		end else if (fire && is_final) begin
			busy_q <= 1'b0;
		end else if (fire) begin
			idx_q <= idx_q + 3'd1;
		end
	end

`ifndef SYNTH
	a_bare_is_error: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.out_valid |-> result.out_last && result.out_error != ERR_NONE)
		else $error("bare word without error code");
	a_data_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.out_valid |-> result.out_error == ERR_NONE)
		else $error("data word carries error code");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= fin)
		else $error("word index past end of job");
	a_last_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.out_last |-> is_final)
		else $error("last word before end of job");
`endif

endmodule
`default_nettype wire
